### design/jsef_pkg.sv
// shared types, constants and byte tables of the json string escape framer
package jsef_pkg;

  // frame lengths, sequencer index width and queue depth
  localparam int HEAD_LEN     = 10;
  localparam int TAIL_LEN     = 2;
  localparam int UNI_LEN      = 6;
  localparam int IDX_W        = 4;
  localparam int QUEUE_DEPTH  = 4;

  // special byte values
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6e;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CTRL_TOP  = 8'h20;

  // escape class of one body byte
  typedef enum logic [1:0] {
    ESC_PLAIN,
    ESC_SHORT,
    ESC_UNI
  } esc_kind_t;

  // emission phase of the back end
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PREFIX,
    PH_ESC,
    PH_SUFFIX
  } phase_t;

  // command passed from front to back through the queue
  typedef struct packed {
    logic [7:0] ch;
    esc_kind_t  kind;
    logic [7:0] short_ch;
    logic       prefix;
    logic       suffix;
  } jsef_cmd_t;

  // prefix {"value":" by position
  function automatic logic [7:0] head_byte(input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = 8'h7b;
      4'd1:    b = 8'h22;
      4'd2:    b = 8'h76;
      4'd3:    b = 8'h61;
      4'd4:    b = 8'h6c;
      4'd5:    b = 8'h75;
      4'd6:    b = 8'h65;
      4'd7:    b = 8'h22;
      4'd8:    b = 8'h3a;
      4'd9:    b = 8'h22;
      default: b = 8'h22;
    endcase
    return b;
  endfunction

  // lowercase hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] b;
    if (nib < 4'd10) begin
      b = CH_ZERO + {4'd0, nib};
    end else begin
      b = 8'h57 + {4'd0, nib};
    end
    return b;
  endfunction

endpackage

### design/json_string_escape_framer.sv
// Frames a raw byte stream as {"value":"..."} with JSON string escaping.
// Each accepted request is a body byte; tlast marks the last byte of a document.
// The front end classifies every byte in the cycle it is taken and writes one
// command into a QUEUE_DEPTH-entry queue, so requests are taken one per cycle
// until the queue fills. The back end sequencer emits one output byte per cycle
// unless out_tready stalls: a plain byte yields 1 byte, a short escape 2, a \u00XX
// escape 6, the prefix before the first byte of a document adds 10 and the suffix
// after the last adds 2, so the output byte count sets the sustained rate. out_tlast
// marks the last output byte caused by one request and out_tuser the closing brace.
module json_string_escape_framer #(
  parameter int QUEUE_DEPTH = jsef_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // final_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // run_last
  output logic       out_tuser   // [0] doc_end
);
  import jsef_pkg::*;

  jsef_cmd_t push_cmd;
  jsef_cmd_t pop_cmd;
  logic      push_valid;
  logic      pop_valid;
  logic      pop_ready;

  // classification front end
  jsef_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .push_ready (in_tready),
    .push_valid (push_valid),
    .push_cmd   (push_cmd)
  );

  // decoupling queue
  jsef_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (in_tready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // emission back end
  jsef_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

### design/jsef_front.sv
// front end: classifies each body byte and tracks whether a document is open
module jsef_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic [7:0]          in_tdata,
  input  logic                in_tlast,
  input  logic                push_ready,
  output logic                push_valid,
  output jsef_pkg::jsef_cmd_t push_cmd
);
  import jsef_pkg::*;

  logic frame_open_r;
  logic frame_open_nxt;
  logic accept;

  assign push_valid = in_tvalid;
  assign accept     = in_tvalid && push_ready;

  // classify the byte into a command
  always_comb begin
    push_cmd.ch       = in_tdata;
    push_cmd.prefix   = !frame_open_r;
    push_cmd.suffix   = in_tlast;
    push_cmd.short_ch = in_tdata;
    push_cmd.kind     = ESC_PLAIN;
    priority if (in_tdata == CH_QUOTE || in_tdata == CH_BSLASH) begin
      push_cmd.kind = ESC_SHORT;
    end else if (in_tdata == CH_BS) begin
      push_cmd.kind     = ESC_SHORT;
      push_cmd.short_ch = CH_LOW_B;
    end else if (in_tdata == CH_FF) begin
      push_cmd.kind     = ESC_SHORT;
      push_cmd.short_ch = CH_LOW_F;
    end else if (in_tdata == CH_LF) begin
      push_cmd.kind     = ESC_SHORT;
      push_cmd.short_ch = CH_LOW_N;
    end else if (in_tdata == CH_CR) begin
      push_cmd.kind     = ESC_SHORT;
      push_cmd.short_ch = CH_LOW_R;
    end else if (in_tdata == CH_TAB) begin
      push_cmd.kind     = ESC_SHORT;
      push_cmd.short_ch = CH_LOW_T;
    end else if (in_tdata < CTRL_TOP) begin
      push_cmd.kind = ESC_UNI;
    end else begin
      push_cmd.kind = ESC_PLAIN;
    end
  end

  // document open flag
  always_comb begin
    frame_open_nxt = frame_open_r;
    if (accept) begin
      frame_open_nxt = !in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
    end else begin
      frame_open_r <= frame_open_nxt;
    end
  end

endmodule

### design/jsef_queue.sv
// small command queue between front and back
module jsef_queue #(
  parameter int DEPTH = jsef_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  jsef_pkg::jsef_cmd_t push_cmd,
  output logic                pop_valid,
  input  logic                pop_ready,
  output jsef_pkg::jsef_cmd_t pop_cmd
);
  import jsef_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jsef_cmd_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### design/jsef_back.sv
// back end: steps through prefix, escape and suffix bytes of each command
module jsef_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  jsef_pkg::jsef_cmd_t pop_cmd,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tlast,
  output logic                out_tuser
);
  import jsef_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  jsef_cmd_t        cmd_r, cmd_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_user_r, out_user_nxt;

  logic             slot_free;
  logic             emit;
  logic             phase_end;
  logic             cmd_done;
  logic [7:0]       cur_byte;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  assign slot_free = !out_valid_r || out_tready;
  assign emit      = (phase_r != PH_IDLE) && slot_free;

  // byte at the current position
  always_comb begin
    cur_byte  = cmd_r.ch;
    phase_end = 1'b0;
    unique case (phase_r)
      PH_PREFIX: begin
        cur_byte  = head_byte(idx_r);
        phase_end = (idx_r == IDX_W'(HEAD_LEN - 1));
      end
      PH_ESC: begin
        unique case (cmd_r.kind)
          ESC_SHORT: begin
            cur_byte  = (idx_r == '0) ? CH_BSLASH : cmd_r.short_ch;
            phase_end = (idx_r == IDX_W'(1));
          end
          ESC_UNI: begin
            unique case (idx_r)
              4'd0:    cur_byte = CH_BSLASH;
              4'd1:    cur_byte = CH_LOW_U;
              4'd2:    cur_byte = CH_ZERO;
              4'd3:    cur_byte = CH_ZERO;
              4'd4:    cur_byte = hex_char(cmd_r.ch[7:4]);
              default: cur_byte = hex_char(cmd_r.ch[3:0]);
            endcase
            phase_end = (idx_r == IDX_W'(UNI_LEN - 1));
          end
          default: begin
            cur_byte  = cmd_r.ch;
            phase_end = 1'b1;
          end
        endcase
      end
      PH_SUFFIX: begin
        cur_byte  = (idx_r == '0) ? CH_QUOTE : CH_RBRACE;
        phase_end = (idx_r == IDX_W'(TAIL_LEN - 1));
      end
      default: begin
        cur_byte  = cmd_r.ch;
        phase_end = 1'b0;
      end
    endcase
  end

  assign cmd_done  = emit && phase_end &&
                     ((phase_r == PH_SUFFIX) || (phase_r == PH_ESC && !cmd_r.suffix));
  assign pop_ready = (phase_r == PH_IDLE) || cmd_done;

  // sequencer next state and output register load
  always_comb begin
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_user_nxt  = out_user_r;

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = cur_byte;
      out_last_nxt  = cmd_done;
      out_user_nxt  = (phase_r == PH_SUFFIX) && phase_end;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (emit) begin
      if (!phase_end) begin
        idx_nxt = idx_r + IDX_W'(1);
      end else begin
        idx_nxt = '0;
        unique case (phase_r)
          PH_PREFIX: phase_nxt = PH_ESC;
          PH_ESC:    phase_nxt = cmd_r.suffix ? PH_SUFFIX : PH_IDLE;
          default:   phase_nxt = PH_IDLE;
        endcase
      end
    end

    if (pop_ready) begin
      if (pop_valid) begin
        cmd_nxt   = pop_cmd;
        idx_nxt   = '0;
        phase_nxt = pop_cmd.prefix ? PH_PREFIX : PH_ESC;
      end else begin
        phase_nxt = PH_IDLE;
      end
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_user_r <= out_user_nxt;
  end

endmodule

### design/jsef_checker.sv
// port-level checker of the framer and its bind
module jsef_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser
);
  import jsef_pkg::*;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled output changed");

  // document end is a closing brace and ends the run
  a_doc_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata == CH_RBRACE)
    else $error("document end not on closing brace");

  // control bytes never leave unescaped
  a_no_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata >= CTRL_TOP)
    else $error("raw control byte on output");

  // nothing is offered right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind json_string_escape_framer jsef_checker u_jsef_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
